FILE: rtl/core/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg: shared definitions of the random bit shuffle
// Table geometry, function codes, the classified command word that the front
// end hands to the back end, and its operation codes.
// ----------------------------------------------------------------------------
package rbs_pkg;

	// Table geometry and random word size.
	localparam int PERM_MAX  = 1024;
	localparam int WORD_BITS = 64;
	localparam int IDX_W     = $clog2(PERM_MAX);
	localparam int SIZE_W    = IDX_W + 1;
	localparam int USED_W    = $clog2(WORD_BITS + 1);

	localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(PERM_MAX);

	// Function codes on the input channel.
	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_WORD  = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// Operations after classification by the front end.
	typedef enum logic [2:0] {
		OP_START,
		OP_WORD,
		OP_READ,
		OP_BADREAD,
		OP_NOP
	} rbs_op_t;

	typedef struct packed {
		rbs_op_t                op;
		logic [WORD_BITS-1:0]   word;
		logic [IDX_W-1:0]       pos;
	} rbs_cmd_t;

endpackage

FILE: rtl/core/rbs_front.sv
// ----------------------------------------------------------------------------
// rbs_front: input acceptance and command queue
// Takes words from the input channel, classifies them into operations
// (including the range check of reads) and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module rbs_front
	import rbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic [WORD_BITS-1:0]  rand_word,
	input  logic [IDX_W-1:0]      position,
	input  logic [SIZE_W-1:0]     eff_size,
	input  logic                  init_busy,
	output logic                  cmd_valid,
	output rbs_cmd_t              cmd,
	input  logic                  cmd_pop
);

	rbs_cmd_t    queue_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	rbs_cmd_t    new_cmd;
	logic        push;

	assign in_ready  = (count_q != 2'd2) && !init_busy;
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];

	// Range check of reads; user must change size only while idle (not enforced).
	always_comb begin
		new_cmd.word = rand_word;
		new_cmd.pos  = position;
		unique case (func)
			FUNC_START: new_cmd.op = OP_START;
			FUNC_WORD:  new_cmd.op = OP_WORD;
			FUNC_READ:  new_cmd.op = ({1'b0, position} >= eff_size) ? OP_BADREAD : OP_READ;
			default:    new_cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_cmd;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("command queue count out of range");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

endmodule

FILE: rtl/core/rbs_back.sv
// ----------------------------------------------------------------------------
// rbs_back: shuffle engine and result register
// Holds the permutation table, sweeps it to the identity, narrows ranges one
// bit a cycle, swaps entries and delivers one result word per command.
// ----------------------------------------------------------------------------
module rbs_back
	import rbs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  rbs_cmd_t           cmd,
	output logic               cmd_pop,
	input  logic [SIZE_W-1:0]  eff_size,
	output logic               init_busy,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   perm_value,
	output logic               done_res,
	output logic               need_bits,
	output logic               position_error
);

	typedef enum logic [6:0] {
		ST_FILL    = 7'b0000001,
		ST_IDLE    = 7'b0000010,
		ST_STEP    = 7'b0000100,
		ST_SWAP_WA = 7'b0001000,
		ST_SWAP_WB = 7'b0010000,
		ST_READ    = 7'b0100000,
		ST_REPLY   = 7'b1000000
	} state_t;

	logic [IDX_W-1:0]      mem [PERM_MAX];

	state_t                state_q;
	logic [IDX_W-1:0]      fill_cnt_q;
	logic                  reply_q;
	logic [IDX_W-1:0]      cur_pos_q;
	logic [SIZE_W-1:0]     range_low_q;
	logic [SIZE_W-1:0]     range_high_q;
	logic                  finished_q;
	logic [WORD_BITS-1:0]  word_q;
	logic [USED_W-1:0]     used_q;
	logic [IDX_W-1:0]      res_value_q;
	logic                  res_perr_q;
	logic [IDX_W-1:0]      rd_a_q;
	logic [IDX_W-1:0]      rd_b_q;
	logic                  out_valid_q;
	logic [IDX_W-1:0]      out_value_q;
	logic                  out_done_q;
	logic                  out_perr_q;

	logic                  mem_we;
	logic [IDX_W-1:0]      waddr;
	logic [IDX_W-1:0]      wdata;
	logic                  rd_en;
	logic [IDX_W-1:0]      raddr_a;
	logic [IDX_W-1:0]      raddr_b;
	logic                  at_end;
	logic                  narrowing;
	logic                  swap_go;
	logic [SIZE_W:0]       range_sum;
	logic [SIZE_W-1:0]     mid;
	logic                  out_load;

	assign at_end    = (SIZE_W'(cur_pos_q) + SIZE_W'(1)) >= eff_size;
	assign narrowing = range_low_q < range_high_q;
	assign swap_go   = !finished_q && !at_end && !narrowing;
	assign range_sum = {1'b0, range_low_q} + {1'b0, range_high_q};
	assign mid       = range_sum[SIZE_W:1];

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign init_busy = (state_q == ST_FILL);
	assign out_load  = (state_q == ST_REPLY) && (!out_valid_q || out_ready);

	// Table port control.
	always_comb begin
		mem_we  = 1'b0;
		waddr   = fill_cnt_q;
		wdata   = fill_cnt_q;
		rd_en   = 1'b0;
		raddr_a = cur_pos_q;
		raddr_b = range_low_q[IDX_W-1:0];
		unique case (state_q)
			ST_FILL: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (cmd_valid && (cmd.op == OP_READ)) begin
					rd_en   = 1'b1;
					raddr_a = cmd.pos;
				end
			end
			ST_STEP: begin
				rd_en = swap_go;
			end
			ST_SWAP_WA: begin
				mem_we = 1'b1;
				waddr  = cur_pos_q;
				wdata  = rd_b_q;
			end
			ST_SWAP_WB: begin
				mem_we = 1'b1;
				waddr  = range_low_q[IDX_W-1:0];
				wdata  = rd_a_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;
			fill_cnt_q   <= '0;
			reply_q      <= 1'b0;
			cur_pos_q    <= '0;
			range_low_q  <= SIZE_W'(1);
			range_high_q <= SIZE_MAX - SIZE_W'(1);
			finished_q   <= 1'b0;
			used_q       <= '0;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					fill_cnt_q <= fill_cnt_q + IDX_W'(1);
					if (fill_cnt_q == IDX_W'(PERM_MAX - 1)) begin
						state_q <= reply_q ? ST_STEP : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.op)
							OP_START: begin
								cur_pos_q    <= '0;
								range_low_q  <= SIZE_W'(1);
								range_high_q <= eff_size - SIZE_W'(1);
								finished_q   <= 1'b0;
								used_q       <= USED_W'(WORD_BITS);
								fill_cnt_q   <= '0;
								reply_q      <= 1'b1;
								state_q      <= ST_FILL;
							end
							OP_WORD: begin
								used_q  <= '0;
								state_q <= ST_STEP;
							end
							OP_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_REPLY;
							end
						endcase
					end
				end
				ST_STEP: begin
					if (finished_q) begin
						state_q <= ST_REPLY;
					end else if (at_end) begin
						finished_q <= 1'b1;
						state_q    <= ST_REPLY;
					end else if (narrowing) begin
						if (used_q == USED_W'(WORD_BITS)) begin
							state_q <= ST_REPLY;
						end else begin
							if (word_q[0]) begin
								range_low_q <= mid + SIZE_W'(1);
							end else begin
								range_high_q <= mid;
							end
							used_q <= used_q + USED_W'(1);
						end
					end else begin
						state_q <= ST_SWAP_WA;
					end
				end
				ST_SWAP_WA: begin
					state_q <= ST_SWAP_WB;
				end
				ST_SWAP_WB: begin
					cur_pos_q    <= cur_pos_q + IDX_W'(1);
					range_low_q  <= SIZE_W'(cur_pos_q) + SIZE_W'(2);
					range_high_q <= eff_size - SIZE_W'(1);
					state_q      <= ST_STEP;
				end
				ST_READ: begin
					state_q <= ST_REPLY;
				end
				ST_REPLY: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Random word shifter and pending result fields.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			word_q      <= cmd.word;
			res_value_q <= '0;
			res_perr_q  <= (cmd.op == OP_BADREAD);
		end else if ((state_q == ST_STEP) && !finished_q && !at_end && narrowing) begin
			word_q <= word_q >> 1;
		end else if (state_q == ST_READ) begin
			res_value_q <= rd_a_q;
		end
	end

	// Result register: the engine loads it while the receiver may still stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= res_value_q;
			out_done_q  <= finished_q;
			out_perr_q  <= res_perr_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign perm_value     = out_value_q;
	assign done_res       = out_done_q;
	assign need_bits      = !out_done_q;
	assign position_error = out_perr_q;

	a_swap_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWAP_WA) |-> (cur_pos_q != range_low_q[IDX_W-1:0]))
		else $error("swap targets the same table entry twice");

	a_finish_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(finished_q) |-> ($past(state_q) == ST_STEP))
		else $error("shuffle finished outside of the step state");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(WORD_BITS))
		else $error("more random bits used than a word holds");

endmodule

FILE: rtl/core/random_bit_shuffle.sv
// ----------------------------------------------------------------------------
// random_bit_shuffle: permutation builder driven by supplied random bits
// Top level with the size register, the front end and the shuffle engine.
// ----------------------------------------------------------------------------
// Usage. Input words carry func, rand_word and position and are taken on
// in_valid && in_ready. Every input word yields exactly one result word on
// out_valid/out_ready with perm_value, done_res, need_bits and position_error.
// A random word is taken as a command, narrows its range one consumed bit at
// a time, does each swap as a table read and two writes, then closes the
// step and loads the result. The bit-serial range narrowing and the single
// write port of the table set how long this takes. A start word restores
// the identity table with a sweep over all 1024 entries and then runs any
// swaps that need no bits. A read fetches its table entry as its result.
// The size register is written on cfg_valid && cfg_ready (always ready) and
// may only change while no word is in flight.
// After reset the engine sweeps all 1024 table entries to the identity,
// with in_ready held low. Up to two words wait in the command queue, and a
// finished result sits in an output register. A stalled receiver stops the
// engine only when the next result is ready while that register is still
// full; the input then stalls once the queue holds two words.
// ----------------------------------------------------------------------------
module random_bit_shuffle
	import rbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [SIZE_W-1:0]     perm_size,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic [WORD_BITS-1:0]  rand_word,
	input  logic [IDX_W-1:0]      position,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IDX_W-1:0]      perm_value,
	output logic                  done_res,
	output logic                  need_bits,
	output logic                  position_error
);

	logic [SIZE_W-1:0]  perm_size_q;
	logic [SIZE_W-1:0]  eff_size;
	logic               cmd_valid;
	rbs_cmd_t           cmd;
	logic               cmd_pop;
	logic               init_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_size_q <= SIZE_MAX;
		end else if (cfg_valid) begin
			perm_size_q <= perm_size;
		end
	end

	// A size of zero behaves as one, and anything above the table depth as
	// the full table.
	always_comb begin
		if (perm_size_q == '0) begin
			eff_size = SIZE_W'(1);
		end else if (perm_size_q > SIZE_MAX) begin
			eff_size = SIZE_MAX;
		end else begin
			eff_size = perm_size_q;
		end
	end

	rbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.rand_word (rand_word),
		.position  (position),
		.eff_size  (eff_size),
		.init_busy (init_busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	rbs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_pop        (cmd_pop),
		.eff_size       (eff_size),
		.init_busy      (init_busy),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.perm_value     (perm_value),
		.done_res       (done_res),
		.need_bits      (need_bits),
		.position_error (position_error)
	);

endmodule
